/* rtl/core/fir_filter_ring_core_assert.svh */
// Assertion macros shared by the FIR ring filter RTL.
`ifndef FIR_FILTER_RING_CORE_ASSERT_SVH
`define FIR_FILTER_RING_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define FRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define FRC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/frc_pkg.sv */
// Shared types and constants of the FIR ring filter.
`default_nettype none

package frc_pkg;

    localparam int DATA_W   = 16;
    localparam int TAP_W    = 4;
    localparam int ACT_W    = 2;
    localparam int TC_W     = 5;
    localparam int TAPS_DEF = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_FILL   = 2'd1,
        ACT_FLUSH  = 2'd2,
        ACT_LOAD   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH,
        ST_DONE
    } t_state;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic              acc_clr;
        logic              issue;
        logic              dly_vld;
        logic              cof_vld;
        logic [DATA_W-1:0] base;
    } t_mac_ctl;

    // Status and result from the multiply-accumulate unit.
    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] filtered;
        logic              sat;
    } t_mac_res;

endpackage

`default_nettype wire

/* rtl/core/frc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module frc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/frc_mac.sv */
// Shared multiply-accumulate unit with rounding and saturation of the sum.
`default_nettype none

module frc_mac #(
    parameter int TAPS = frc_pkg::TAPS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire frc_pkg::t_mac_ctl           i_ctl,
    input  wire logic [frc_pkg::DATA_W-1:0]  i_dly_data,
    input  wire logic [frc_pkg::DATA_W-1:0]  i_cof_data,
    output frc_pkg::t_mac_res                o_res
);

    localparam int ACC_W     = 32 + $clog2(TAPS);
    localparam int CoefReset = (32768 + TAPS / 2) / TAPS;

    localparam logic signed [ACC_W-1:0] RoundHalf = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0] SatMax    = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SatMin    = -ACC_W'(32768);

    logic                      r_p1;
    logic                      r_p2;
    logic                      r_dv;
    logic                      r_cv;
    logic signed [31:0]        r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    logic signed [frc_pkg::DATA_W-1:0] w_smp;
    logic signed [frc_pkg::DATA_W-1:0] w_cof;
    logic signed [ACC_W-1:0]           w_rnd;
    logic signed [ACC_W-1:0]           w_shf;

    // Entries never written since reset, fill or flush read as their default.
    assign w_smp = r_dv ? i_dly_data : i_ctl.base;
    assign w_cof = r_cv ? i_cof_data : frc_pkg::DATA_W'(CoefReset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
        end else begin
            r_p1 <= i_ctl.issue;
            r_p2 <= r_p1;
        end
        r_dv   <= i_ctl.dly_vld;
        r_cv   <= i_ctl.cof_vld;
        r_prod <= w_smp * w_cof;
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (r_p2) begin
            r_acc <= r_acc + {{(ACC_W-32){r_prod[31]}}, r_prod};
        end
    end

    // Round half up, then drop the 15 fraction bits.
    assign w_rnd = r_acc + RoundHalf;
    assign w_shf = w_rnd >>> 15;

    always_comb begin
        o_res.busy = r_p1 | r_p2;
        if (w_shf > SatMax) begin
            o_res.filtered = 16'h7fff;
            o_res.sat      = 1'b1;
        end else if (w_shf < SatMin) begin
            o_res.filtered = 16'h8000;
            o_res.sat      = 1'b1;
        end else begin
            o_res.filtered = w_shf[frc_pkg::DATA_W-1:0];
            o_res.sat      = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/frc_ctrl.sv */
// Sequencer: ring pointer, valid bits, memory addressing and action handling.
`default_nettype none

module frc_ctrl #(
    parameter int TAPS = frc_pkg::TAPS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire frc_pkg::t_action                 i_action,
    input  wire logic [frc_pkg::DATA_W-1:0]       i_value,
    input  wire logic [frc_pkg::TAP_W-1:0]        i_tap,
    input  wire logic [frc_pkg::TC_W-1:0]         i_tap_count,
    input  wire logic                             i_tc_all,
    input  wire logic                             i_out_free,
    output logic                                  o_done,
    output logic [frc_pkg::DATA_W-1:0]            o_last,
    output logic                                  o_sat,
    output logic                                  o_dly_we,
    output logic [$clog2(TAPS)-1:0]               o_dly_waddr,
    output logic [frc_pkg::DATA_W-1:0]            o_dly_wdata,
    output logic                                  o_cof_we,
    output logic [$clog2(TAPS)-1:0]               o_cof_waddr,
    output logic [frc_pkg::DATA_W-1:0]            o_cof_wdata,
    output logic [$clog2(TAPS)-1:0]               o_dly_raddr,
    output logic [$clog2(TAPS)-1:0]               o_cof_raddr,
    output frc_pkg::t_mac_ctl                     o_mac_ctl,
    input  wire frc_pkg::t_mac_res                i_mac_res
);

    localparam int IDX_W = $clog2(TAPS);
    localparam int CNT_W = $clog2(TAPS + 1);
    localparam int CMP_W = (CNT_W > frc_pkg::TC_W) ? CNT_W : frc_pkg::TC_W;
    localparam int TW    = (CNT_W > frc_pkg::TAP_W) ? CNT_W : frc_pkg::TAP_W;

    frc_pkg::t_state r_state, n_state;

    logic [IDX_W-1:0]          r_write_slot, n_write_slot;
    logic [IDX_W-1:0]          r_rd_slot,    n_rd_slot;
    logic [CNT_W-1:0]          r_idx,        n_idx;
    logic [TAPS-1:0]           r_dvalid,     n_dvalid;
    logic [TAPS-1:0]           r_cvalid,     n_cvalid;
    logic [frc_pkg::DATA_W-1:0] r_base,      n_base;
    logic [frc_pkg::DATA_W-1:0] r_last,      n_last;
    logic                      r_sat,        n_sat;

    logic             w_accept;
    logic             w_issue;
    logic [CMP_W-1:0] w_tc;
    logic [CMP_W-1:0] w_n;
    logic             w_run_end;
    logic             w_tap_ok;

    // Number of taps to sum: all of them until the register is written.
    assign w_tc      = CMP_W'(i_tap_count);
    assign w_n       = (i_tc_all || (w_tc > CMP_W'(TAPS))) ? CMP_W'(TAPS) : w_tc;
    assign w_run_end = (CMP_W'(r_idx) == w_n);
    assign w_tap_ok  = (TW'(i_tap) < TW'(TAPS));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            frc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_action == frc_pkg::ACT_SAMPLE) ? frc_pkg::ST_RUN
                                                                : frc_pkg::ST_DONE;
                end
            end
            frc_pkg::ST_RUN: begin
                if (w_run_end) begin
                    n_state = frc_pkg::ST_DRAIN;
                end
            end
            frc_pkg::ST_DRAIN: begin
                if (!i_mac_res.busy) begin
                    n_state = frc_pkg::ST_FINISH;
                end
            end
            frc_pkg::ST_FINISH: begin
                n_state = frc_pkg::ST_DONE;
            end
            frc_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = frc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = frc_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_ready = 1'b0;
        w_issue    = 1'b0;
        o_done     = 1'b0;
        case (r_state)
            frc_pkg::ST_IDLE:   o_in_ready = 1'b1;
            frc_pkg::ST_RUN:    w_issue    = !w_run_end;
            frc_pkg::ST_DRAIN:  w_issue    = 1'b0;
            frc_pkg::ST_FINISH: w_issue    = 1'b0;
            frc_pkg::ST_DONE:   o_done     = i_out_free;
            default:            o_in_ready = 1'b0;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // Memory ports and unit control.
    assign o_dly_we    = w_accept && (i_action == frc_pkg::ACT_SAMPLE);
    assign o_dly_waddr = r_write_slot;
    assign o_dly_wdata = i_value;
    assign o_cof_we    = w_accept && (i_action == frc_pkg::ACT_LOAD) && w_tap_ok;
    assign o_cof_waddr = IDX_W'(i_tap);
    assign o_cof_wdata = i_value;
    assign o_dly_raddr = r_rd_slot;
    assign o_cof_raddr = r_idx[IDX_W-1:0];

    assign o_mac_ctl.acc_clr = o_dly_we;
    assign o_mac_ctl.issue   = w_issue;
    assign o_mac_ctl.dly_vld = r_dvalid[r_rd_slot];
    assign o_mac_ctl.cof_vld = r_cvalid[r_idx[IDX_W-1:0]];
    assign o_mac_ctl.base    = r_base;

    assign o_last = r_last;
    assign o_sat  = r_sat;

    // Datapath register updates.
    always_comb begin
        n_write_slot = r_write_slot;
        n_rd_slot    = r_rd_slot;
        n_idx        = r_idx;
        n_dvalid     = r_dvalid;
        n_cvalid     = r_cvalid;
        n_base       = r_base;
        n_last       = r_last;
        n_sat        = r_sat;
        if (w_accept) begin
            n_sat = 1'b0;
            case (i_action)
                frc_pkg::ACT_SAMPLE: begin
                    n_dvalid[r_write_slot] = 1'b1;
                    n_rd_slot              = r_write_slot;
                    n_idx                  = '0;
                    n_write_slot = (r_write_slot == IDX_W'(TAPS - 1)) ? '0
                                                                      : r_write_slot + 1'b1;
                end
                frc_pkg::ACT_FILL: begin
                    n_dvalid = '0;
                    n_base   = i_value;
                    n_last   = i_value;
                end
                frc_pkg::ACT_FLUSH: begin
                    n_dvalid = '0;
                    n_base   = '0;
                    n_last   = '0;
                end
                frc_pkg::ACT_LOAD: begin
                    if (w_tap_ok) begin
                        n_cvalid[IDX_W'(i_tap)] = 1'b1;
                    end
                end
                default: begin
                    n_sat = 1'b0;
                end
            endcase
        end
        if (w_issue) begin
            n_idx     = r_idx + 1'b1;
            n_rd_slot = (r_rd_slot == '0) ? IDX_W'(TAPS - 1) : r_rd_slot - 1'b1;
        end
        if (r_state == frc_pkg::ST_FINISH) begin
            n_last = i_mac_res.filtered;
            n_sat  = i_mac_res.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= frc_pkg::ST_IDLE;
            r_write_slot <= '0;
            r_dvalid     <= '0;
            r_cvalid     <= '0;
            r_base       <= '0;
            r_last       <= '0;
            r_sat        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_write_slot <= n_write_slot;
            r_dvalid     <= n_dvalid;
            r_cvalid     <= n_cvalid;
            r_base       <= n_base;
            r_last       <= n_last;
            r_sat        <= n_sat;
        end
        r_rd_slot <= n_rd_slot;
        r_idx     <= n_idx;
    end

endmodule

`default_nettype wire

/* rtl/core/fir_filter_ring_core.sv */
// Top level of the FIR filter over a ring-buffer delay line.
`default_nettype none

// Direct-form FIR filter whose delay line and coefficients sit in two small
// synchronous RAMs. Each request carries one action in s_axis_tuser: a sample
// enters the ring over the oldest slot and the filter sums coefficient k times
// the sample delayed by k for the first tap_count delays (newest first); fill
// sets every delay slot and the last output to the given value; flush sets
// them to zero; load writes one Q1.15 coefficient, and a load to an index
// beyond the store is dropped. Every request produces exactly one result
// carrying the last filtered output and, for a sample, a flag that says the
// rounded sum was clipped to 16 bits. The sum is rounded half up, shifted
// right by 15 and saturated. One shared multiply-accumulate walks the taps at
// one tap per cycle. A sample is then held until the unit's pipeline drains,
// its result is captured and the output register has room for it; only then
// can the next request be accepted. Fill, flush and load skip the walk and
// wait only for room in the output register.
// A result waiting in the output register does not block the next request;
// only a result that finds the output register still full waits there.
// Coefficients come up as round(32768 / TAPS) and the delay line as zero right
// after reset, with no clearing pass: per-entry valid bits supply those values
// until an entry is written, and fill or flush simply clears the delay-line
// valid bits. The tap_count register sums all TAPS taps until it is first
// written, and it may only be written while no request is in flight.

module fir_filter_ring_core #(
    parameter int TAPS = frc_pkg::TAPS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Configuration: tap_count.
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [frc_pkg::TC_W-1:0]   i_cfg_wr_data,
    // Request stream.
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [23:0]                s_axis_tdata,  // value[15:0], tap[19:16], zero pad
    input  wire logic [frc_pkg::ACT_W-1:0]  s_axis_tuser,  // action[1:0]
    // Result stream.
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [15:0]                     m_axis_tdata,  // filtered[15:0]
    output logic                            m_axis_tuser   // saturated[0]
);

`include "fir_filter_ring_core_assert.svh"

    localparam int IDX_W = $clog2(TAPS);

    logic [frc_pkg::TC_W-1:0] r_tap_count;
    logic                     r_tc_all;

    logic                       r_out_valid;
    logic [frc_pkg::DATA_W-1:0] r_out_data;
    logic                       r_out_sat;

    logic                       w_out_free;
    logic                       w_done;
    logic [frc_pkg::DATA_W-1:0] w_last;
    logic                       w_sat;

    logic                       w_dly_we;
    logic [IDX_W-1:0]           w_dly_waddr;
    logic [frc_pkg::DATA_W-1:0] w_dly_wdata;
    logic                       w_cof_we;
    logic [IDX_W-1:0]           w_cof_waddr;
    logic [frc_pkg::DATA_W-1:0] w_cof_wdata;
    logic [IDX_W-1:0]           w_dly_raddr;
    logic [IDX_W-1:0]           w_cof_raddr;
    logic [frc_pkg::DATA_W-1:0] w_dly_rdata;
    logic [frc_pkg::DATA_W-1:0] w_cof_rdata;

    logic                       w_in_hs;
    logic                       w_out_clip;
    logic                       w_out_rail;

    frc_pkg::t_mac_ctl w_mac_ctl;
    frc_pkg::t_mac_res w_mac_res;

    // The tap count register; until its first write every tap is summed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= '0;
            r_tc_all    <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_tap_count <= i_cfg_wr_data;
            r_tc_all    <= 1'b0;
        end
    end

    frc_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (frc_pkg::t_action'(s_axis_tuser)),
        .i_value     (s_axis_tdata[15:0]),
        .i_tap       (s_axis_tdata[19:16]),
        .i_tap_count (r_tap_count),
        .i_tc_all    (r_tc_all),
        .i_out_free  (w_out_free),
        .o_done      (w_done),
        .o_last      (w_last),
        .o_sat       (w_sat),
        .o_dly_we    (w_dly_we),
        .o_dly_waddr (w_dly_waddr),
        .o_dly_wdata (w_dly_wdata),
        .o_cof_we    (w_cof_we),
        .o_cof_waddr (w_cof_waddr),
        .o_cof_wdata (w_cof_wdata),
        .o_dly_raddr (w_dly_raddr),
        .o_cof_raddr (w_cof_raddr),
        .o_mac_ctl   (w_mac_ctl),
        .i_mac_res   (w_mac_res)
    );

    // Delay line, addressed by ring slot.
    frc_ram #(
        .WIDTH (frc_pkg::DATA_W),
        .DEPTH (TAPS)
    ) u_dly_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_dly_we),
        .i_wr_addr (w_dly_waddr),
        .i_wr_data (w_dly_wdata),
        .i_rd_en   (w_mac_ctl.issue),
        .i_rd_addr (w_dly_raddr),
        .o_rd_data (w_dly_rdata)
    );

    // Coefficient store, addressed by delay.
    frc_ram #(
        .WIDTH (frc_pkg::DATA_W),
        .DEPTH (TAPS)
    ) u_cof_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_cof_we),
        .i_wr_addr (w_cof_waddr),
        .i_wr_data (w_cof_wdata),
        .i_rd_en   (w_mac_ctl.issue),
        .i_rd_addr (w_cof_raddr),
        .o_rd_data (w_cof_rdata)
    );

    frc_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mac_ctl),
        .i_dly_data (w_dly_rdata),
        .i_cof_data (w_cof_rdata),
        .o_res      (w_mac_res)
    );

    // Output register: a finished result lands here when it is empty or
    // being emptied in the same cycle.
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_done) begin
            r_out_data <= w_last;
            r_out_sat  <= w_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sat;

    assign w_in_hs    = s_axis_tvalid && s_axis_tready;
    assign w_out_clip = m_axis_tvalid && m_axis_tuser;
    assign w_out_rail = (m_axis_tdata == 16'h7fff) || (m_axis_tdata == 16'h8000);

    // An accepted request always keeps the block busy for the next cycle.
    `FRC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_in_hs, !s_axis_tready, "double accept")
    // A result is only handed over when the output register can take it.
    `FRC_ASSERT_IMP(a_done_needs_room, i_clk, i_rst_n, w_done, w_out_free, "output overrun")
    // A clipped result sits at one of the two rails.
    `FRC_ASSERT_IMP(a_sat_at_rail, i_clk, i_rst_n, w_out_clip, w_out_rail, "clip off the rails")

endmodule

`default_nettype wire

/* tb/tb_fir_filter_ring_core.sv */
// Self-checking testbench for the FIR ring filter core: directed corners, then random actions.
`timescale 1ns / 1ps

module tb_fir_filter_ring_core;

    import frc_pkg::*;

    localparam int    CLK_HALF       = 5;
    localparam int    RESET_CYCLES   = 7;
    localparam int    WATCHDOG_LIMIT = 2000;
    // Covers the time a sample occupies the block, with some margin.
    localparam int    SETTLE_CYCLES  = 30;
    localparam int    RANDOM_PHASES  = 8;
    localparam int    PHASE_ITEMS    = 116;
    localparam logic [15:0] S16_MAX  = 16'h7FFF;
    localparam logic [15:0] S16_MIN  = 16'h8000;

    // One filter result as it leaves the block.
    typedef struct packed {
        logic [DATA_W-1:0] filtered;
        logic              saturated;
    } t_filter_result;

    // Mirrors the delay ring, coefficient store and tap count of the block, and
    // holds the filter outputs that are still on their way.
    class filter_scoreboard;
        logic signed [DATA_W-1:0] ring [TAPS_DEF];
        logic signed [DATA_W-1:0] coef [TAPS_DEF];
        logic [TAP_W-1:0]         wr_slot;
        logic signed [DATA_W-1:0] last_out;
        int unsigned              taps_used;
        t_filter_result           pending_q [$];
        int                       error_count;

        function new();
            wr_slot     = '0;
            last_out    = '0;
            taps_used   = TAPS_DEF;
            error_count = 0;
            foreach (ring[k]) begin
                ring[k] = '0;
                coef[k] = 16'((32768 + TAPS_DEF / 2) / TAPS_DEF);
            end
        endfunction

        function void set_tap_count(logic [TC_W-1:0] count);
            taps_used = count;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // Works out the result that an accepted request leads to.
        function void note_request(t_action act, logic signed [DATA_W-1:0] val,
                                   logic [TAP_W-1:0] tp);
            longint         acc;
            longint         rounded;
            int             n;
            int             slot;
            logic           sat;
            t_filter_result res;
            sat = 1'b0;
            case (act)
                ACT_SAMPLE: begin
                    ring[wr_slot] = val;
                    n   = (taps_used > TAPS_DEF) ? TAPS_DEF : taps_used;
                    acc = 0;
                    // Coefficient k always pairs with the sample delayed by k.
                    for (int k = 0; k < n; k++) begin
                        slot = (int'(wr_slot) + TAPS_DEF - k) % TAPS_DEF;
                        acc += longint'(coef[k]) * longint'(ring[slot]);
                    end
                    rounded = (acc + 64'sd16384) >>> 15;
                    if (rounded > 32767) begin
                        rounded = 32767;
                        sat     = 1'b1;
                    end else if (rounded < -32768) begin
                        rounded = -32768;
                        sat     = 1'b1;
                    end
                    last_out = rounded[DATA_W-1:0];
                    wr_slot  = wr_slot + 1'b1;
                end
                ACT_FILL: begin
                    foreach (ring[k]) ring[k] = val;
                    last_out = val;
                end
                ACT_FLUSH: begin
                    foreach (ring[k]) ring[k] = '0;
                    last_out = '0;
                end
                default: begin
                    if (int'(tp) < TAPS_DEF) coef[tp] = val;
                end
            endcase
            res.filtered  = last_out;
            res.saturated = sat;
            pending_q.push_back(res);
        endfunction

        task report_mismatch(string what);
            if (error_count < 40) $display("MISMATCH at %0t: %s", $realtime, what);
            error_count++;
        endtask

        task check_result(logic [DATA_W-1:0] got_filtered, logic got_sat);
            t_filter_result exp;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result filtered=%0d saturated=%0b",
                                          $signed(got_filtered), got_sat));
            end else begin
                exp = pending_q.pop_front();
                if (got_filtered !== exp.filtered)
                    report_mismatch($sformatf("filtered got %0d, expected %0d",
                                              $signed(got_filtered), $signed(exp.filtered)));
                if (got_sat !== exp.saturated)
                    report_mismatch($sformatf("saturated got %0b, expected %0b",
                                              got_sat, exp.saturated));
            end
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [TC_W-1:0]     i_cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata = '0;
    logic [ACT_W-1:0]    s_axis_tuser = ACT_SAMPLE;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;
    logic                m_axis_tuser;

    filter_scoreboard    sb = new();
    int                  send_idle_rate = 0;
    int                  stall_rate = 0;
    int                  stall_left = 0;
    int                  quiet_cycles = 0;

    fir_filter_ring_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Result side back-pressure: random stall bursts.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (stall_rate != 0 && $urandom_range(0, 15) < stall_rate) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 10);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Signals are read right at the edge, before any register of this step updates.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Ends a run in which neither stream moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Presents one request, at random after an idle burst, and returns at
    // the edge where it is accepted. The valid stays high on return.
    task automatic send_request(t_action act, logic [15:0] val, logic [TAP_W-1:0] tp);
        int gap;
        if (send_idle_rate != 0 && $urandom_range(0, 15) < send_idle_rate) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, tp, val};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(act, val, tp);
    endtask

    // Lets the block go idle, then lets it finish any internal work.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes tap_count; only called once the block is idle.
    task automatic write_tap_count(logic [TC_W-1:0] count);
        drain_block();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= count;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_tap_count(count);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return S16_MAX;
            1:       return S16_MIN;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 512)) - 16'd256;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Coefficients are mostly modest so that both clipped and clean sums occur.
    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return S16_MAX;
            1:       return S16_MIN;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 8191)) - 16'd4096;
        endcase
    endfunction

    function automatic logic [TC_W-1:0] pick_tap_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return TC_W'($urandom_range(TAPS_DEF + 1, 31));
            default: return TC_W'($urandom_range(1, TAPS_DEF));
        endcase
    endfunction

    task automatic send_random_request();
        logic [TAP_W-1:0] tp;
        int               pick;
        tp   = TAP_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 19);
        if (pick < 12)      send_request(ACT_SAMPLE, pick_sample(), tp);
        else if (pick < 16) send_request(ACT_LOAD, pick_coef(), tp);
        else if (pick < 18) send_request(ACT_FILL, pick_sample(), tp);
        else                send_request(ACT_FLUSH, pick_sample(), tp);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first at the reset tap count and coefficients.
        send_idle_rate = 3;
        stall_rate     = 3;
        send_request(ACT_SAMPLE, S16_MAX, 4'h0);
        send_request(ACT_SAMPLE, S16_MIN, 4'hF);
        send_request(ACT_SAMPLE, 16'd100, 4'h5);
        send_request(ACT_LOAD, S16_MAX, 4'h0);
        send_request(ACT_LOAD, S16_MAX, 4'h1);
        send_request(ACT_LOAD, S16_MAX, 4'h2);
        send_request(ACT_LOAD, S16_MIN, 4'hF);
        // Full-scale ring with large coefficients clips upward, then downward.
        send_request(ACT_FILL, S16_MAX, 4'h0);
        send_request(ACT_SAMPLE, S16_MAX, 4'h0);
        send_request(ACT_SAMPLE, S16_MIN, 4'h0);
        send_request(ACT_FILL, S16_MIN, 4'hF);
        send_request(ACT_SAMPLE, S16_MIN, 4'hF);
        send_request(ACT_FLUSH, S16_MAX, 4'hA);
        send_request(ACT_SAMPLE, 16'd1, 4'h0);
        // Minus one times minus one lands just above the top of the range.
        send_request(ACT_LOAD, S16_MIN, 4'h0);
        send_request(ACT_SAMPLE, S16_MIN, 4'h3);

        // No taps summed: the sample still enters the ring, the output is zero.
        write_tap_count('0);
        send_request(ACT_SAMPLE, S16_MAX, 4'h0);
        send_request(ACT_SAMPLE, 16'h1234, 4'h0);
        // A count above the ring size acts as the full ring.
        write_tap_count('1);
        send_request(ACT_SAMPLE, S16_MIN, 4'h0);
        send_request(ACT_SAMPLE, S16_MAX, 4'h0);
        write_tap_count(TC_W'(1));
        send_request(ACT_SAMPLE, S16_MIN, 4'h0);
        send_request(ACT_SAMPLE, 16'h0042, 4'h0);

        // Random part: one tap count per phase, with varying idle pressure.
        // The pressure is set before the drain so that no stall burst spills
        // into a quiet phase.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 1 || p % 3 == 2) begin
                send_idle_rate = 0;
                stall_rate     = 0;
            end else begin
                send_idle_rate = $urandom_range(1, 6);
                stall_rate     = $urandom_range(1, 6);
            end
            if (p == 0 || p == RANDOM_PHASES - 1) write_tap_count(TC_W'(TAPS_DEF));
            else if (p == 1)                      write_tap_count(TC_W'(1));
            else                                  write_tap_count(pick_tap_count());
            for (int i = 0; i < PHASE_ITEMS; i++) send_random_request();
        end

        drain_block();
        if (sb.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
